/* sv/sca_pkg.sv */
package sca_pkg;

    // Field widths fixed by the stream format
    localparam int TASK_ID_W = 9;
    localparam int SPEED_W   = 16;
    localparam int SQ_W      = 2 * SPEED_W;
    localparam int ENERGY_W  = 50;
    localparam int CNT_W     = 17;
    localparam int SLOT_W    = 13;
    localparam int IDLE_E_W  = 32;
    localparam int PROD_W    = SLOT_W + IDLE_E_W;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 104;

    // APB register map
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int PROCS_W   = 5;
    localparam logic REG_PROCS     = 1'b0;
    localparam logic REG_IDLE_ENER = 1'b1;

    localparam logic [TASK_ID_W-1:0] IDLE_ID    = '1;
    localparam logic [CNT_W-1:0]     CNT_MAX    = '1;
    localparam logic [SLOT_W-1:0]    SLOT_MAX   = '1;
    localparam logic [ENERGY_W-1:0]  ENERGY_MAX = '1;

    // Totals of one finished schedule, handed to the result path
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [CNT_W-1:0]    idle;
        logic [CNT_W-1:0]    mig;
        logic [CNT_W-1:0]    sw;
        logic [SLOT_W-1:0]   slots;
    } sca_totals_t;

endpackage

/* sv/sca_result.sv */
module sca_result
    import sca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  sca_totals_t          totals,
    input  logic [IDLE_E_W-1:0]  idle_energy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // energy_total, idle_cells, migrations, switches
);

    logic                in_v_reg;
    sca_totals_t         in_tot_reg;
    logic                mul_v_reg;
    logic [ENERGY_W-1:0] mul_energy_reg;
    logic [PROD_W-1:0]   mul_prod_reg;
    logic [CNT_W-1:0]    mul_idle_reg;
    logic [CNT_W-1:0]    mul_mig_reg;
    logic [CNT_W-1:0]    mul_sw_reg;
    logic                out_v_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                 out_ready;
    logic                 mul_ready;
    logic [ENERGY_W:0]    total_sum;
    logic [ENERGY_W-1:0]  total_sat;
    logic [M_TDATA_W-1:0] out_data_next;

    // Ready chain through the three result registers
    assign out_ready  = !out_v_reg || m_tready;
    assign mul_ready  = !mul_v_reg || out_ready;
    assign push_ready = !in_v_reg || mul_ready;

    // Final add of idle energy, saturating
    assign total_sum = {1'b0, mul_energy_reg} + (ENERGY_W + 1)'(mul_prod_reg);
    assign total_sat = total_sum[ENERGY_W] ? ENERGY_MAX : total_sum[ENERGY_W-1:0];
    assign out_data_next = {(M_TDATA_W - ENERGY_W - 3 * CNT_W)'(0),
                            mul_sw_reg, mul_mig_reg, mul_idle_reg, total_sat};

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (push_ready)
                in_v_reg <= push_valid;
            if (mul_ready)
                mul_v_reg <= in_v_reg;
            if (out_ready)
                out_v_reg <= mul_v_reg;
        end
    end

    // Payload: capture, slot count times idle energy, sum
    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
            in_tot_reg <= totals;
        if (mul_ready && in_v_reg)
        begin
            mul_energy_reg <= in_tot_reg.energy;
            mul_prod_reg   <= PROD_W'(in_tot_reg.slots) * PROD_W'(idle_energy);
            mul_idle_reg   <= in_tot_reg.idle;
            mul_mig_reg    <= in_tot_reg.mig;
            mul_sw_reg     <= in_tot_reg.sw;
        end
        if (out_ready && mul_v_reg)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* sv/schedule_cost_accumulator.sv */
// Schedule cost accumulator.
// Cells of a multiprocessor schedule enter on the s_ stream, slot by slot and
// processor by processor within a slot; s_tlast marks the final cell. Each
// cell carries a task id (-1 idle) and a Q4.12 speed. On the final cell one
// transaction leaves on the m_ stream with the Q26.24 energy (squared speeds
// plus slot count times idle_energy_per_slot), idle cells, migrations and
// context switches, all saturating; the stores are then cleared.
// Throughput: one cell per cycle while the result path has room. The per-processor
// and per-task tables sit in registered-read memories; each cell reads both on
// acceptance and writes them back when it leaves stage A, with forwarding between adjacent cells.
// The result passes through stage A (table update), the capture register, the
// idle-energy multiply and the final saturating add into the output register.
// When the receiver stalls, input is still taken until the three-deep result
// path is full, then s_tready drops. Reset clears all counters and table
// valid bits at once; no clearing pass is needed. Configuration (APB, regs at
// 0x0 and 0x4) must be written only while the block is idle; it is not enforced.
module schedule_cost_accumulator
    import sca_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int MAX_TASKS = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // cell stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // task_id[8:0], speed[24:9], zero pad
    input  logic                 s_tlast,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // energy_total[49:0], idle_cells[66:50],
                                            // migrations[83:67], switches[100:84]
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int POS_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int PCNT_W  = $clog2(MAX_PROCS + 1);
    localparam int CFG_W   = (PCNT_W > PROCS_W) ? PCNT_W : PROCS_W;
    localparam int TASK_AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    // Configuration registers
    logic [PROCS_W-1:0]  procs_reg;
    logic [IDLE_E_W-1:0] idle_ener_reg;

    // Front position
    logic [POS_W-1:0]    pos_reg;

    // Stage A: cell under update
    logic                a_v_reg;
    logic [TASK_ID_W-1:0] a_tid_reg;
    logic [POS_W-1:0]    a_pos_reg;
    logic [TASK_AW-1:0]  a_task_reg;
    logic                a_task_ok_reg;
    logic                a_last_reg;
    logic [SQ_W-1:0]     a_sq_reg;

    // Tables and their read data / forwarding
    logic [TASK_ID_W-1:0] pt_mem_reg [MAX_PROCS];
    logic [MAX_PROCS-1:0] pt_valid_reg;
    logic [TASK_ID_W-1:0] pt_rd_reg;
    logic                 pt_fwd_reg;
    logic [TASK_ID_W-1:0] pt_fwd_data_reg;
    logic [POS_W-1:0]     lp_mem_reg [MAX_TASKS];
    logic [MAX_TASKS-1:0] lp_valid_reg;
    logic [POS_W-1:0]     lp_rd_reg;
    logic                 lp_fwd_reg;
    logic [POS_W-1:0]     lp_fwd_data_reg;

    // Accumulators
    logic [ENERGY_W-1:0] energy_reg;
    logic [CNT_W-1:0]    idle_cnt_reg;
    logic [CNT_W-1:0]    mig_cnt_reg;
    logic [CNT_W-1:0]    sw_cnt_reg;
    logic [SLOT_W-1:0]   slot_cnt_reg;

    logic                 adv;
    logic                 in_acc;
    logic [TASK_ID_W-1:0] in_tid;
    logic [SPEED_W-1:0]   in_speed;
    logic                 in_task_ok;
    logic [TASK_AW-1:0]   in_task;
    logic [CFG_W-1:0]     procs_ext;
    logic [PCNT_W-1:0]    procs_eff;
    logic [POS_W-1:0]     pos_cur;
    logic [PCNT_W-1:0]    pos_plus;
    logic [POS_W-1:0]     pos_next;

    logic                 a_go;
    logic [TASK_ID_W-1:0] prev_tid;
    logic                 seen;
    logic [POS_W-1:0]     last_proc;
    logic                 busy;
    logic                 is_switch;
    logic                 is_mig;
    logic [ENERGY_W:0]    energy_sum;
    logic [ENERGY_W-1:0]  energy_next;
    logic [CNT_W-1:0]     idle_cnt_next;
    logic [CNT_W-1:0]     mig_cnt_next;
    logic [CNT_W-1:0]     sw_cnt_next;
    logic [SLOT_W-1:0]    slot_cnt_next;
    sca_totals_t          totals;
    logic                 res_ready;
    logic                 cfg_wr;

    // APB port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            procs_reg     <= PROCS_W'(1);
            idle_ener_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_PROCS:     procs_reg     <= pwdata[PROCS_W-1:0];
                REG_IDLE_ENER: idle_ener_reg <= pwdata;
                default:       idle_ener_reg <= idle_ener_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PROCS:     prdata = PDATA_W'(procs_reg);
            REG_IDLE_ENER: prdata = idle_ener_reg;
            default:       prdata = '0;
        endcase
    end

    // Input unpacking and handshake
    assign adv      = res_ready;
    assign s_tready = adv;
    assign in_acc   = s_tvalid && s_tready;
    assign in_tid   = s_tdata[TASK_ID_W-1:0];
    assign in_speed = s_tdata[TASK_ID_W +: SPEED_W];
    assign in_task_ok = !in_tid[TASK_ID_W-1] &&
                        ({24'd0, in_tid[TASK_ID_W-2:0]} < 32'(MAX_TASKS));
    assign in_task  = TASK_AW'(in_tid[TASK_ID_W-2:0]);

    // Processor position with clamped processor count
    assign procs_ext = CFG_W'(procs_reg);
    assign procs_eff = (procs_ext == '0) ? PCNT_W'(1) :
                       (procs_ext > CFG_W'(MAX_PROCS)) ? PCNT_W'(MAX_PROCS) :
                       PCNT_W'(procs_ext);
    assign pos_cur   = (PCNT_W'(pos_reg) >= procs_eff) ? '0 : pos_reg;
    assign pos_plus  = PCNT_W'(pos_cur) + PCNT_W'(1);
    assign pos_next  = (s_tlast || pos_plus >= procs_eff) ? '0 : POS_W'(pos_plus);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (in_acc)
            pos_reg <= pos_next;
    end

    // Stage A load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (adv)
            a_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_tid_reg       <= in_tid;
            a_pos_reg       <= pos_cur;
            a_task_reg      <= in_task;
            a_task_ok_reg   <= in_task_ok;
            a_last_reg      <= s_tlast;
            a_sq_reg        <= SQ_W'(in_speed) * SQ_W'(in_speed);
            pt_rd_reg       <= pt_mem_reg[pos_cur];
            lp_rd_reg       <= lp_mem_reg[in_task];
            pt_fwd_reg      <= a_v_reg && (a_pos_reg == pos_cur);
            pt_fwd_data_reg <= a_tid_reg;
            lp_fwd_reg      <= a_v_reg && a_task_ok_reg && (a_task_reg == in_task);
            lp_fwd_data_reg <= a_pos_reg;
        end
    end

    // Table write-back
    assign a_go = a_v_reg && adv;

    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            pt_mem_reg[a_pos_reg] <= a_tid_reg;
            if (a_task_ok_reg)
                lp_mem_reg[a_task_reg] <= a_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg <= '0;
            lp_valid_reg <= '0;
        end
        else if (a_go)
        begin
            if (a_last_reg)
            begin
                pt_valid_reg <= '0;
                lp_valid_reg <= '0;
            end
            else
            begin
                pt_valid_reg[a_pos_reg] <= 1'b1;
                if (a_task_ok_reg)
                    lp_valid_reg[a_task_reg] <= 1'b1;
            end
        end
    end

    // Cell evaluation: previous task on this processor, last processor of task
    assign prev_tid  = !pt_valid_reg[a_pos_reg] ? IDLE_ID :
                       pt_fwd_reg ? pt_fwd_data_reg : pt_rd_reg;
    assign seen      = lp_valid_reg[a_task_reg];
    assign last_proc = lp_fwd_reg ? lp_fwd_data_reg : lp_rd_reg;
    assign busy      = (a_tid_reg != IDLE_ID);
    assign is_switch = busy && (prev_tid != IDLE_ID) && (prev_tid != a_tid_reg);
    assign is_mig    = a_task_ok_reg && (!seen || last_proc != a_pos_reg);

    // Saturating accumulator updates
    assign energy_sum    = {1'b0, energy_reg} + (ENERGY_W + 1)'(a_sq_reg);
    assign energy_next   = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
    assign idle_cnt_next = (!busy && idle_cnt_reg != CNT_MAX) ?
                           idle_cnt_reg + CNT_W'(1) : idle_cnt_reg;
    assign mig_cnt_next  = (is_mig && mig_cnt_reg != CNT_MAX) ?
                           mig_cnt_reg + CNT_W'(1) : mig_cnt_reg;
    assign sw_cnt_next   = (is_switch && sw_cnt_reg != CNT_MAX) ?
                           sw_cnt_reg + CNT_W'(1) : sw_cnt_reg;
    assign slot_cnt_next = (a_pos_reg == '0 && slot_cnt_reg != SLOT_MAX) ?
                           slot_cnt_reg + SLOT_W'(1) : slot_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg   <= '0;
            idle_cnt_reg <= '0;
            mig_cnt_reg  <= '0;
            sw_cnt_reg   <= '0;
            slot_cnt_reg <= '0;
        end
        else if (a_go)
        begin
            if (a_last_reg)
            begin
                energy_reg   <= '0;
                idle_cnt_reg <= '0;
                mig_cnt_reg  <= '0;
                sw_cnt_reg   <= '0;
                slot_cnt_reg <= '0;
            end
            else
            begin
                energy_reg   <= energy_next;
                idle_cnt_reg <= idle_cnt_next;
                mig_cnt_reg  <= mig_cnt_next;
                sw_cnt_reg   <= sw_cnt_next;
                slot_cnt_reg <= slot_cnt_next;
            end
        end
    end

    // Hand the totals of a finished schedule to the result path
    assign totals.energy = energy_next;
    assign totals.idle   = idle_cnt_next;
    assign totals.mig    = mig_cnt_next;
    assign totals.sw     = sw_cnt_next;
    assign totals.slots  = slot_cnt_next;

    sca_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (a_v_reg && a_last_reg),
        .push_ready  (res_ready),
        .totals      (totals),
        .idle_energy (idle_ener_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Input only backs up when a result is waiting at the output
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Position restarts after the final cell
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (pos_reg == '0))
        else $error("processor position not cleared after final cell");

    // Counters and tables cleared once a schedule completes
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (a_v_reg && a_last_reg && adv) |=>
            (idle_cnt_reg == '0 && mig_cnt_reg == '0 && sw_cnt_reg == '0 &&
             pt_valid_reg == '0 && lp_valid_reg == '0))
        else $error("stores not cleared after final cell");

    // A waiting result stays put while the receiver stalls
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while receiver stalled");

endmodule

/* verif/schedule_cost_accumulator_test.sv */
module schedule_cost_accumulator_test
    import sca_pkg::*;
();

    localparam int NPROC        = 16;
    localparam int NTASK        = 256;
    localparam int RANDOM_CELLS = 1430;
    localparam int LONG_HOLD    = 100;
    localparam int QUIET_CYCLES = 8;
    localparam int WATCHDOG     = 4000;
    localparam int HOLD_PHASE   = 2;

    localparam logic [PADDR_W-1:0] ADDR_PROCS     = {REG_PROCS, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_IDLE_ENER = {REG_IDLE_ENER, 2'b00};

    // Totals of one scored schedule, as carried on m_tdata
    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [CNT_W-1:0]    idle;
        logic [CNT_W-1:0]    mig;
        logic [CNT_W-1:0]    sw;
    } score_t;

    // One schedule cell; typed marks a hand-written expected score
    typedef struct {
        logic [TASK_ID_W-1:0] task_id;
        logic [SPEED_W-1:0]   speed;
        logic                 last;
        bit                   typed;
        score_t               score;
    } cell_t;

    typedef struct {
        bit                   set_cfg;
        logic [PROCS_W-1:0]   procs;
        logic [IDLE_E_W-1:0]  idle_e;
        logic [TASK_ID_W-1:0] task_id;
        logic [SPEED_W-1:0]   speed;
        logic                 last;
        bit                   typed;
        score_t               score;
    } dir_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    schedule_cost_accumulator #(
        .MAX_PROCS (NPROC),
        .MAX_TASKS (NTASK)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Directed cells; rows with typed set carry an expected score read off by hand
    dir_row_t dir_rows [0:15] = '{
        // after reset: one busy cell, first appearance only
        '{1'b0, 5'd0, 32'h0, 9'h000, 16'h0000, 1'b1, 1'b1,
          '{50'h0, 17'd0, 17'd1, 17'd0}},
        // idle cell at full speed
        '{1'b0, 5'd0, 32'h0, IDLE_ID, 16'hFFFF, 1'b1, 1'b1,
          '{50'hFFFE0001, 17'd1, 17'd0, 17'd0}},
        // two processors, tasks swap rows: switches and migrations
        '{1'b1, 5'd2, 32'h0100_0000, 9'h001, 16'h1000, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0, 32'h0, 9'h002, 16'h1000, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0, 32'h0, 9'h002, 16'h2000, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0, 32'h0, 9'h001, 16'h2000, 1'b0, 1'b0, '0},
        // most negative id is busy but never migrates
        '{1'b0, 5'd0, 32'h0, 9'h100, 16'h8000, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0, 32'h0, IDLE_ID, 16'h0000, 1'b1, 1'b0, '0},
        // zero processors acts as one, maximum idle energy
        '{1'b1, 5'd0, 32'hFFFF_FFFF, 9'h0FF, 16'hFFFF, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0, 32'h0, 9'h0FF, 16'h0000, 1'b1, 1'b0, '0},
        // count above the maximum, schedule ends mid-slot
        '{1'b1, 5'd17, 32'h5, 9'h000, 16'h0000, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0, 32'h0, 9'h000, 16'h0000, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0, 32'h0, 9'h000, 16'h0000, 1'b1, 1'b1,
          '{50'h5, 17'd0, 17'd3, 17'd0}},
        // negative ids other than idle switch against busy tasks
        '{1'b1, 5'd1, 32'h0, 9'h1FE, 16'h7FFF, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0, 32'h0, 9'h0FF, 16'h0001, 1'b0, 1'b0, '0},
        '{1'b0, 5'd0, 32'h0, 9'h1FE, 16'h0000, 1'b1, 1'b0, '0}
    };

    // Configuration and accumulation state of the scoring predictor
    logic [PROCS_W-1:0]   cfg_procs;
    logic [IDLE_E_W-1:0]  cfg_idle;
    logic [ENERGY_W-1:0]  acc_energy;
    logic [CNT_W-1:0]     n_idle;
    logic [CNT_W-1:0]     n_mig;
    logic [CNT_W-1:0]     n_sw;
    logic [SLOT_W-1:0]    n_slots;
    int unsigned          cur_proc;
    logic [TASK_ID_W-1:0] prev_task [NPROC];
    bit                   task_seen [NTASK];
    int unsigned          task_proc [NTASK];

    cell_t  cell_q [$];
    score_t score_q [$];
    int     n_queued;
    int     n_taken;
    int     errors;
    int     hold_asks;

    function automatic int unsigned eff_procs(logic [PROCS_W-1:0] p);
        if (p == 0)
            return 1;
        if (p > NPROC)
            return NPROC;
        return p;
    endfunction

    function automatic void clear_schedule();
        acc_energy = '0;
        n_idle     = '0;
        n_mig      = '0;
        n_sw       = '0;
        n_slots    = '0;
        cur_proc   = 0;
        for (int i = 0; i < NPROC; i++)
            prev_task[i] = IDLE_ID;
        for (int i = 0; i < NTASK; i++)
        begin
            task_seen[i] = 1'b0;
            task_proc[i] = 0;
        end
    endfunction

    // Score one accepted cell; on the final cell queue the expected totals
    function automatic void account_cell(cell_t c);
        int unsigned np;
        int unsigned pos;
        int unsigned tid;
        logic [63:0] sum;
        logic        busy;
        score_t      s;
        n_taken++;
        np = eff_procs(cfg_procs);
        if (cur_proc >= np)
            cur_proc = 0;
        pos = cur_proc;
        if (pos == 0 && n_slots != SLOT_MAX)
            n_slots++;
        sum = 64'(acc_energy) + 64'(c.speed) * 64'(c.speed);
        acc_energy = (sum > 64'(ENERGY_MAX)) ? ENERGY_MAX : sum[ENERGY_W-1:0];
        busy = (c.task_id != IDLE_ID);
        if (!busy && n_idle != CNT_MAX)
            n_idle++;
        if (busy && prev_task[pos] != IDLE_ID && prev_task[pos] != c.task_id
            && n_sw != CNT_MAX)
            n_sw++;
        prev_task[pos] = c.task_id;
        // only non-negative ids inside the task table take part in migrations
        if (!c.task_id[TASK_ID_W-1] && c.task_id < NTASK)
        begin
            tid = c.task_id;
            if ((!task_seen[tid] || task_proc[tid] != pos) && n_mig != CNT_MAX)
                n_mig++;
            task_seen[tid] = 1'b1;
            task_proc[tid] = pos;
        end
        cur_proc = (pos + 1 >= np) ? 0 : pos + 1;
        if (!c.last)
            return;
        sum = 64'(acc_energy) + 64'(n_slots) * 64'(cfg_idle);
        s.energy = (sum > 64'(ENERGY_MAX)) ? ENERGY_MAX : sum[ENERGY_W-1:0];
        s.idle   = n_idle;
        s.mig    = n_mig;
        s.sw     = n_sw;
        score_q.insert(score_q.size(), c.typed ? c.score : s);
        clear_schedule();
    endfunction

    function automatic logic [TASK_ID_W-1:0] pick_task(int unsigned pool);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return IDLE_ID;
        if (r == 2)
            return TASK_ID_W'($urandom_range(0, (1 << TASK_ID_W) - 1));
        return TASK_ID_W'($urandom_range(0, pool - 1));
    endfunction

    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    function automatic logic [PROCS_W-1:0] pick_procs(int phase);
        case (phase)
            0: return PROCS_W'(NPROC);
            1: return 5'd1;
            2: return 5'd0;
            3: return '1;
            4: return PROCS_W'(NPROC + 1);
            default:
                if ($urandom_range(0, 9) == 0)
                    return ($urandom_range(0, 1) == 0) ? 5'd0
                                                       : PROCS_W'($urandom_range(17, 31));
                else
                    return PROCS_W'($urandom_range(1, NPROC));
        endcase
    endfunction

    function automatic logic [IDLE_E_W-1:0] pick_idle(int phase);
        if (phase == 0)
            return '0;
        if (phase == 1)
            return '1;
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return IDLE_E_W'($urandom);
        endcase
    endfunction

    // Queue one run of random cells; closed runs end on a final cell
    function automatic void queue_schedule(int len, bit closed, int unsigned pool);
        cell_t c;
        for (int i = 0; i < len; i++)
        begin
            c.task_id = pick_task(pool);
            c.speed   = pick_speed();
            c.last    = closed && (i == len - 1);
            c.typed   = 1'b0;
            c.score   = '0;
            cell_q.insert(cell_q.size(), c);
            n_queued++;
        end
    endfunction

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_PROCS)
            cfg_procs = data[PROCS_W-1:0];
        else
            cfg_idle = data[IDLE_E_W-1:0];
    endtask

    task automatic set_config(logic [PROCS_W-1:0] procs, logic [IDLE_E_W-1:0] idle_e);
        apb_write(ADDR_PROCS, PDATA_W'(procs));
        apb_write(ADDR_IDLE_ENER, PDATA_W'(idle_e));
    endtask

    // Hold the sender until every cell is taken and every score has come back
    task automatic wait_quiet();
        while (n_taken != n_queued || score_q.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Cell sender: bursts of random length with random gaps
    cell_t cur_cell;
    int    burst_left;
    int    gap_left;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                account_cell(cur_cell);
            if (s_tvalid && !s_tready)
            begin
                // transaction still pending, hold it
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (cell_q.size() != 0)
            begin
                cur_cell = cell_q.pop_front();
                s_tdata  <= S_TDATA_W'({cur_cell.speed, cur_cell.task_id});
                s_tlast  <= cur_cell.last;
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: stall pattern changes now and then; long hold on request
    rx_mode_t    rx_mode = RX_OPEN;
    int          mode_left;
    int          hold_left;
    int          holds_done;
    int unsigned rx_tick;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (holds_done != hold_asks)
            begin
                holds_done = hold_asks;
                hold_left  = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            rx_tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_EVERY4: m_tready <= (rx_tick % 4 == 0);
                    default:   m_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // Score checker
    score_t got;
    score_t want;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.energy = m_tdata[ENERGY_W-1:0];
            got.idle   = m_tdata[ENERGY_W +: CNT_W];
            got.mig    = m_tdata[ENERGY_W + CNT_W +: CNT_W];
            got.sw     = m_tdata[ENERGY_W + 2 * CNT_W +: CNT_W];
            if (score_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: energy=%h idle=%0d mig=%0d sw=%0d",
                             got.energy, got.idle, got.mig, got.sw);
            end
            else
            begin
                want = score_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected energy=%h idle=%0d mig=%0d sw=%0d, %s",
                                 want.energy, want.idle, want.mig, want.sw,
                                 $sformatf("got energy=%h idle=%0d mig=%0d sw=%0d",
                                           got.energy, got.idle, got.mig, got.sw));
                end
            end
        end
    end

    // Watchdog: too long without any transaction or register access
    int stuck;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            stuck = 0;
        else
            stuck++;
        if (stuck >= WATCHDOG)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        cell_t       c;
        int          phase;
        int unsigned pool;
        int unsigned np;
        int          len;
        int          kind;

        cfg_procs = 5'd1;
        cfg_idle  = '0;
        clear_schedule();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed cells
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_cfg)
            begin
                wait_quiet();
                set_config(dir_rows[i].procs, dir_rows[i].idle_e);
            end
            c.task_id = dir_rows[i].task_id;
            c.speed   = dir_rows[i].speed;
            c.last    = dir_rows[i].last;
            c.typed   = dir_rows[i].typed;
            c.score   = dir_rows[i].score;
            cell_q.insert(cell_q.size(), c);
            n_queued++;
        end

        // random phases, each with its own configuration
        phase = 0;
        while (n_queued < $size(dir_rows) + RANDOM_CELLS)
        begin
            wait_quiet();
            set_config(pick_procs(phase), pick_idle(phase));
            np   = eff_procs(cfg_procs);
            pool = ($urandom_range(0, 3) == 0) ? NTASK : $urandom_range(2, 12);
            kind = (phase == HOLD_PHASE) ? 0 : $urandom_range(0, 9);
            if (kind == 0)
            begin
                // receiver holds off while many short schedules pile up
                hold_asks++;
                repeat ($urandom_range(12, 20))
                    queue_schedule($urandom_range(1, 2), 1'b1, pool);
            end
            else if (kind == 1)
            begin
                // processor count changes in the middle of a schedule
                queue_schedule($urandom_range(1, 3 * np), 1'b0, pool);
                wait_quiet();
                apb_write(ADDR_PROCS, PDATA_W'(pick_procs(-1)));
                queue_schedule($urandom_range(1, 4 * eff_procs(cfg_procs)), 1'b1, pool);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 4) == 0)
                        len = $urandom_range(1, 3 * np + 2);
                    else
                        len = np * $urandom_range(1, 6);
                    queue_schedule(len, 1'b1, pool);
                end
            end
            phase++;
        end

        // drain
        while (n_taken != n_queued || score_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/sca_pkg.sv
sv/sca_result.sv
sv/schedule_cost_accumulator.sv
verif/schedule_cost_accumulator_test.sv
